FILE: src/hsvr_pkg.sv
package hsvr_pkg;

   // field widths
   localparam int HUE_W = 9;
   localparam int PCT_W = 7;
   localparam int FRAC_W = 6;    // x weight, 0..60
   localparam int PROD_W = 14;   // v*s and v*(100-s), up to 10000
   localparam int SCALE_W = 20;  // scaled components, up to 600000
   localparam int QIN_W = 18;    // 17*n/64, up to 159375
   localparam int CH_W = 8;
   localparam int RECIP_W = 18;
   localparam int MULT_W = QIN_W + RECIP_W;

   localparam logic [HUE_W-1:0] FULL_TURN = 9'd360;
   localparam logic [HUE_W-1:0] DEG_60 = 9'd60;
   localparam logic [HUE_W-1:0] DEG_120 = 9'd120;
   localparam logic [HUE_W-1:0] DEG_180 = 9'd180;
   localparam logic [HUE_W-1:0] DEG_240 = 9'd240;
   localparam logic [HUE_W-1:0] DEG_300 = 9'd300;
   localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;
   localparam logic [SCALE_W-1:0] SECTOR_SCALE = 20'd60;

   // floor(a/625) == (a*RECIP_K) >> RECIP_SHIFT for a <= 159375
   localparam logic [RECIP_W-1:0] RECIP_K = 18'd214749;
   localparam int RECIP_SHIFT = 27;

   // what a channel takes before the offset is added
   typedef enum logic [1:0] {
      ROLE_ZERO,
      ROLE_X,
      ROLE_C
   } role_type;

   typedef struct packed {
      role_type red;
      role_type green;
      role_type blue;
   } roles_type;

   typedef struct packed {
      logic [PCT_W-1:0] sat;
      logic [PCT_W-1:0] val;
      logic [FRAC_W-1:0] frac;
      roles_type roles;
   } decode_type;

   typedef struct packed {
      logic [PROD_W-1:0] vs;
      logic [PROD_W-1:0] vm;
      logic [FRAC_W-1:0] frac;
      roles_type roles;
   } prod_type;

   typedef struct packed {
      logic [SCALE_W-1:0] cc;
      logic [SCALE_W-1:0] xx;
      logic [SCALE_W-1:0] mm;
      roles_type roles;
   } scale_type;

   typedef struct packed {
      logic [QIN_W-1:0] red;
      logic [QIN_W-1:0] green;
      logic [QIN_W-1:0] blue;
   } quot_in_type;

endpackage

FILE: src/hsvr_prep.sv
module hsvr_prep (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  logic [hsvr_pkg::HUE_W-1:0] hue,
   input  logic [hsvr_pkg::PCT_W-1:0] saturation,
   input  logic [hsvr_pkg::PCT_W-1:0] brightness,
   output logic out_valid,
   input  logic out_ready,
   output hsvr_pkg::prod_type out_data
);

   logic dec_valid_ff, dec_valid_in, dec_ready;
   hsvr_pkg::decode_type dec_ff, dec_in;
   logic prod_valid_ff, prod_valid_in, prod_ready;
   hsvr_pkg::prod_type prod_ff, prod_in;

   logic [hsvr_pkg::HUE_W-1:0] hue_w, t_deg;
   logic [hsvr_pkg::PCT_W-1:0] sat_c, val_c, sat_inv;

   // stage 1: clamp, wrap hue, sector roles and x weight
   always_comb begin
      sat_c = (saturation > hsvr_pkg::PCT_MAX) ? hsvr_pkg::PCT_MAX : saturation;
      val_c = (brightness > hsvr_pkg::PCT_MAX) ? hsvr_pkg::PCT_MAX : brightness;
      hue_w = (hue >= hsvr_pkg::FULL_TURN) ? hue - hsvr_pkg::FULL_TURN : hue;
      if (hue_w >= hsvr_pkg::DEG_240) begin
         t_deg = hue_w - hsvr_pkg::DEG_240;
      end else if (hue_w >= hsvr_pkg::DEG_120) begin
         t_deg = hue_w - hsvr_pkg::DEG_120;
      end else begin
         t_deg = hue_w;
      end
      dec_in.sat = sat_c;
      dec_in.val = val_c;
      // 60 - |t - 60|
      if (t_deg >= hsvr_pkg::DEG_60) begin
         dec_in.frac = hsvr_pkg::FRAC_W'(hsvr_pkg::DEG_120 - t_deg);
      end else begin
         dec_in.frac = hsvr_pkg::FRAC_W'(t_deg);
      end
      if (hue_w < hsvr_pkg::DEG_60) begin
         dec_in.roles = '{hsvr_pkg::ROLE_C, hsvr_pkg::ROLE_X, hsvr_pkg::ROLE_ZERO};
      end else if (hue_w < hsvr_pkg::DEG_120) begin
         dec_in.roles = '{hsvr_pkg::ROLE_X, hsvr_pkg::ROLE_C, hsvr_pkg::ROLE_ZERO};
      end else if (hue_w < hsvr_pkg::DEG_180) begin
         dec_in.roles = '{hsvr_pkg::ROLE_ZERO, hsvr_pkg::ROLE_C, hsvr_pkg::ROLE_X};
      end else if (hue_w < hsvr_pkg::DEG_240) begin
         dec_in.roles = '{hsvr_pkg::ROLE_ZERO, hsvr_pkg::ROLE_X, hsvr_pkg::ROLE_C};
      end else if (hue_w < hsvr_pkg::DEG_300) begin
         dec_in.roles = '{hsvr_pkg::ROLE_X, hsvr_pkg::ROLE_ZERO, hsvr_pkg::ROLE_C};
      end else begin
         dec_in.roles = '{hsvr_pkg::ROLE_C, hsvr_pkg::ROLE_ZERO, hsvr_pkg::ROLE_X};
      end
   end

   assign in_ready = !dec_valid_ff || dec_ready;
   assign dec_valid_in = in_ready ? in_valid : dec_valid_ff;

   // stage 2: v*s and v*(100-s)
   assign dec_ready = !prod_valid_ff || prod_ready;
   assign prod_valid_in = dec_ready ? dec_valid_ff : prod_valid_ff;
   assign sat_inv = hsvr_pkg::PCT_MAX - dec_ff.sat;

   always_comb begin
      prod_in.vs = hsvr_pkg::PROD_W'(dec_ff.val) * hsvr_pkg::PROD_W'(dec_ff.sat);
      prod_in.vm = hsvr_pkg::PROD_W'(dec_ff.val) * hsvr_pkg::PROD_W'(sat_inv);
      prod_in.frac = dec_ff.frac;
      prod_in.roles = dec_ff.roles;
   end

   assign prod_ready = out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         dec_valid_ff <= 1'b0;
         prod_valid_ff <= 1'b0;
      end else begin
         dec_valid_ff <= dec_valid_in;
         prod_valid_ff <= prod_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         dec_ff <= dec_in;
      end
      if (dec_ready && dec_valid_ff) begin
         prod_ff <= prod_in;
      end
   end

   assign out_valid = prod_valid_ff;
   assign out_data = prod_ff;

endmodule

FILE: src/hsvr_mix.sv
module hsvr_mix (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  hsvr_pkg::prod_type in_data,
   output logic out_valid,
   input  logic out_ready,
   output hsvr_pkg::quot_in_type out_data
);

   logic scl_valid_ff, scl_valid_in, scl_ready;
   hsvr_pkg::scale_type scl_ff, scl_in;
   logic qin_valid_ff, qin_valid_in;
   hsvr_pkg::quot_in_type qin_ff, qin_in;

   // pick c, x or zero for a channel, add the offset, then 17*n/64
   function automatic logic [hsvr_pkg::QIN_W-1:0] chan_prescale(
      input hsvr_pkg::role_type role,
      input hsvr_pkg::scale_type s
   );
      logic [hsvr_pkg::SCALE_W-1:0] comp;
      logic [hsvr_pkg::SCALE_W-1:0] n;
      logic [hsvr_pkg::SCALE_W+3:0] n17;
      case (role)
         hsvr_pkg::ROLE_C: comp = s.cc;
         hsvr_pkg::ROLE_X: comp = s.xx;
         default: comp = '0;
      endcase
      n = comp + s.mm;
      n17 = {n, 4'b0000} + {4'b0000, n};
      return n17[hsvr_pkg::SCALE_W+3:6];
   endfunction

   // stage 3: scale products to the common 600000 denominator
   always_comb begin
      scl_in.cc = hsvr_pkg::SCALE_W'(in_data.vs) * hsvr_pkg::SECTOR_SCALE;
      scl_in.xx = hsvr_pkg::SCALE_W'(in_data.vs) * hsvr_pkg::SCALE_W'(in_data.frac);
      scl_in.mm = hsvr_pkg::SCALE_W'(in_data.vm) * hsvr_pkg::SECTOR_SCALE;
      scl_in.roles = in_data.roles;
   end

   assign in_ready = !scl_valid_ff || scl_ready;
   assign scl_valid_in = in_ready ? in_valid : scl_valid_ff;

   // stage 4: per-channel sum and prescale
   always_comb begin
      qin_in.red = chan_prescale(scl_ff.roles.red, scl_ff);
      qin_in.green = chan_prescale(scl_ff.roles.green, scl_ff);
      qin_in.blue = chan_prescale(scl_ff.roles.blue, scl_ff);
   end

   assign scl_ready = !qin_valid_ff || out_ready;
   assign qin_valid_in = scl_ready ? scl_valid_ff : qin_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         scl_valid_ff <= 1'b0;
         qin_valid_ff <= 1'b0;
      end else begin
         scl_valid_ff <= scl_valid_in;
         qin_valid_ff <= qin_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         scl_ff <= scl_in;
      end
      if (scl_ready && scl_valid_ff) begin
         qin_ff <= qin_in;
      end
   end

   assign out_valid = qin_valid_ff;
   assign out_data = qin_ff;

endmodule

FILE: src/hsvr_quant.sv
module hsvr_quant (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  hsvr_pkg::quot_in_type in_data,
   output logic out_valid,
   input  logic out_ready,
   output logic [hsvr_pkg::CH_W-1:0] red,
   output logic [hsvr_pkg::CH_W-1:0] green,
   output logic [hsvr_pkg::CH_W-1:0] blue
);

   logic q_valid_ff, q_valid_in;
   logic [hsvr_pkg::CH_W-1:0] red_ff, green_ff, blue_ff;
   logic [hsvr_pkg::CH_W-1:0] red_in, green_in, blue_in;

   // floor(a/625) by reciprocal multiply, exact over the whole input range
   function automatic logic [hsvr_pkg::CH_W-1:0] div625(
      input logic [hsvr_pkg::QIN_W-1:0] a
   );
      logic [hsvr_pkg::MULT_W-1:0] prod;
      prod = hsvr_pkg::MULT_W'(a) * hsvr_pkg::MULT_W'(hsvr_pkg::RECIP_K);
      return prod[hsvr_pkg::RECIP_SHIFT+hsvr_pkg::CH_W-1:hsvr_pkg::RECIP_SHIFT];
   endfunction

   always_comb begin
      red_in = div625(in_data.red);
      green_in = div625(in_data.green);
      blue_in = div625(in_data.blue);
   end

   assign in_ready = !q_valid_ff || out_ready;
   assign q_valid_in = in_ready ? in_valid : q_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         q_valid_ff <= 1'b0;
      end else begin
         q_valid_ff <= q_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         red_ff <= red_in;
         green_ff <= green_in;
         blue_ff <= blue_in;
      end
   end

   assign out_valid = q_valid_ff;
   assign red = red_ff;
   assign green = green_ff;
   assign blue = blue_ff;

endmodule

FILE: src/hsv_to_rgb565.sv
// hsv to rgb conversion with rgb565 packing, one pixel per request
//
// request channel (req_): hue in whole degrees, saturation and brightness
// in whole percent. saturation and brightness above 100 are clamped, hue
// from 360 up wraps by 360.
// response channel (rsp_): 8-bit red, green, blue (truncated) and the
// packed rgb565 word, one response per request, in request order.
//
// five register stages: decode, v*s products, scaling to the common
// denominator, per-channel sum, reciprocal-multiply quotient. the last
// stage is the response register. a new request is taken every cycle
// while rsp_tready stays high; throughput is then one pixel per clock.
// each stage has its own valid bit and takes new data when it is empty or
// its successor moves, so bubbles close up while the receiver stalls and
// req_tready drops only once all five stages hold a pixel. nothing is
// dropped or repeated. reset clears the valid bits; data registers keep
// whatever they held.
module hsv_to_rgb565 (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // [8:0] hue, [15:9] saturation, [22:16] brightness, [23] zero
   input  logic [23:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // [7:0] red, [15:8] green, [23:16] blue, [39:24] packed_565
   output logic [39:0] rsp_tdata
);

   logic prep_valid, prep_ready;
   hsvr_pkg::prod_type prep_data;
   logic mix_valid, mix_ready;
   hsvr_pkg::quot_in_type mix_data;
   logic [hsvr_pkg::CH_W-1:0] red, green, blue;
   logic [15:0] packed_565;

   // stages 1 and 2: clamp, sector decode, v*s and v*(100-s)
   hsvr_prep u_prep (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .hue        (req_tdata[8:0]),
      .saturation (req_tdata[15:9]),
      .brightness (req_tdata[22:16]),
      .out_valid  (prep_valid),
      .out_ready  (prep_ready),
      .out_data   (prep_data)
   );

   // stages 3 and 4: c, x, m over 600000, then channel sums prescaled by 17/64
   hsvr_mix u_mix (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (prep_valid),
      .in_ready  (prep_ready),
      .in_data   (prep_data),
      .out_valid (mix_valid),
      .out_ready (mix_ready),
      .out_data  (mix_data)
   );

   // stage 5: divide by 625, response register
   hsvr_quant u_quant (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mix_valid),
      .in_ready  (mix_ready),
      .in_data   (mix_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .red       (red),
      .green     (green),
      .blue      (blue)
   );

   // red top five, green middle six, blue low five
   assign packed_565 = {red[7:3], green[7:2], blue[7:3]};
   assign rsp_tdata = {packed_565, blue, green, red};

endmodule

FILE: tb/hsv_to_rgb565_tb.sv
module hsv_to_rgb565_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HUE_W = hsvr_pkg::HUE_W;
   localparam int PCT_W = hsvr_pkg::PCT_W;
   localparam int CH_W = hsvr_pkg::CH_W;

   localparam int RESET_CYCLES = 9;
   localparam int RANDOM_PIXELS = 1950;
   // pipeline is five stages deep, drain with some margin
   localparam int DRAIN_CYCLES = 20;
   // cycles with no request or response moving before the run is abandoned
   localparam int WATCHDOG_LIMIT = 2000;
   // percent of cycles in which each side holds back
   localparam int IDLE_PERCENT = 7;
   // window of requests / responses with no idling at all
   localparam int QUIET_FROM = 700;
   localparam int QUIET_TO = 1200;

   // one expected response, field for field
   typedef struct packed {
      logic [CH_W-1:0] red;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] blue;
      logic [15:0] rgb565;
   } color_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   // [8:0] hue, [15:9] saturation, [22:16] brightness, [23] zero
   logic [23:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   // [7:0] red, [15:8] green, [23:16] blue, [39:24] packed_565
   logic [39:0] rsp_tdata;

   logic [23:0] pixel_queue[$];       // requests not yet put on the bus
   color_type pending_colors[$];      // colors owed by the block, oldest first
   int sent_count = 0;
   int received_count = 0;
   int error_count = 0;
   int clamped_count = 0;
   int stall_cycles = 0;

   hsv_to_rgb565 i_dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   always #1 clock = ~clock;

   // floor(255 * scaled / 600000), scaled is over the common denominator
   function automatic logic [CH_W-1:0] to_level(int unsigned scaled);
      int unsigned level;
      level = (255 * scaled) / 600000;
      if (level > 255) begin
         level = 255;
      end
      return level[CH_W-1:0];
   endfunction

   // expected color of one pixel, exact integer math
   function automatic color_type hsv_color(logic [HUE_W-1:0] hue_in,
                                           logic [PCT_W-1:0] sat_in,
                                           logic [PCT_W-1:0] val_in);
      int unsigned hue, sat, val, t, span, cc, xx, mm, r1, g1, b1;
      color_type color;
      sat = (sat_in > 100) ? 100 : sat_in;
      val = (val_in > 100) ? 100 : val_in;
      hue = (hue_in >= 360) ? hue_in - 360 : hue_in;
      // distance from the middle of the double sector sets the x weight
      t = hue % 120;
      span = (t >= 60) ? t - 60 : 60 - t;
      cc = val * sat * 60;
      xx = val * sat * (60 - span);
      mm = val * (100 - sat) * 60;
      if (hue < 60) begin
         r1 = cc; g1 = xx; b1 = 0;
      end else if (hue < 120) begin
         r1 = xx; g1 = cc; b1 = 0;
      end else if (hue < 180) begin
         r1 = 0; g1 = cc; b1 = xx;
      end else if (hue < 240) begin
         r1 = 0; g1 = xx; b1 = cc;
      end else if (hue < 300) begin
         r1 = xx; g1 = 0; b1 = cc;
      end else begin
         r1 = cc; g1 = 0; b1 = xx;
      end
      color.red = to_level(r1 + mm);
      color.green = to_level(g1 + mm);
      color.blue = to_level(b1 + mm);
      color.rgb565 = {color.red[7:3], color.green[7:2], color.blue[7:3]};
      return color;
   endfunction

   task automatic add_pixel(int unsigned hue, int unsigned sat, int unsigned val);
      pixel_queue.push_back({1'b0, val[PCT_W-1:0], sat[PCT_W-1:0], hue[HUE_W-1:0]});
      if (hue >= 360 || sat > 100 || val > 100) begin
         clamped_count++;
      end
   endtask

   // request driver: fresh pixel only when the bus is empty or just moved
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            // the block owes one color for every request it takes
            pending_colors.push_back(hsv_color(req_tdata[8:0], req_tdata[15:9],
                                               req_tdata[22:16]));
            sent_count++;
         end
         if (!req_tvalid || req_tready) begin
            if (pixel_queue.size() > 0 &&
                ((sent_count >= QUIET_FROM && sent_count < QUIET_TO) ||
                 $urandom_range(99) >= IDLE_PERCENT)) begin
               req_tdata <= pixel_queue.pop_front();
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response monitor and random back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            received_count++;
            if (pending_colors.size() == 0) begin
               $error("response with no request outstanding: %h", rsp_tdata);
               error_count++;
            end else begin
               color_type want;
               want = pending_colors.pop_front();
               if (rsp_tdata[7:0] !== want.red) begin
                  $error("red: expected %0d, actual %0d", want.red, rsp_tdata[7:0]);
                  error_count++;
               end
               if (rsp_tdata[15:8] !== want.green) begin
                  $error("green: expected %0d, actual %0d", want.green, rsp_tdata[15:8]);
                  error_count++;
               end
               if (rsp_tdata[23:16] !== want.blue) begin
                  $error("blue: expected %0d, actual %0d", want.blue, rsp_tdata[23:16]);
                  error_count++;
               end
               if (rsp_tdata[39:24] !== want.rgb565) begin
                  $error("packed_565: expected %h, actual %h", want.rgb565,
                         rsp_tdata[39:24]);
                  error_count++;
               end
            end
         end
         rsp_tready <= (received_count >= QUIET_FROM && received_count < QUIET_TO) ||
                       ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   // watchdog: nothing moving on either side for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("hsv_to_rgb565 regression: fail");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      int total;
      int unsigned pick;

      // sector edges at full saturation and brightness
      add_pixel(0, 100, 100);
      add_pixel(59, 100, 100);
      add_pixel(60, 100, 100);
      add_pixel(119, 100, 100);
      add_pixel(120, 100, 100);
      add_pixel(179, 100, 100);
      add_pixel(180, 100, 100);
      add_pixel(239, 100, 100);
      add_pixel(240, 100, 100);
      add_pixel(299, 100, 100);
      add_pixel(300, 100, 100);
      add_pixel(359, 100, 100);
      // hue of a full turn wraps to red, all-ones fields clamp and wrap
      add_pixel(360, 100, 100);
      add_pixel(511, 127, 127);
      // black and white corners, and a half-saturated, half-bright pixel
      add_pixel(0, 0, 0);
      add_pixel(0, 0, 100);
      add_pixel(200, 100, 0);
      add_pixel(30, 50, 50);
      // out of range hue, saturation and brightness, then assorted in-range pixels
      add_pixel(90, 101, 127);
      add_pixel(400, 127, 50);
      add_pixel(256, 64, 64);
      add_pixel(170, 1, 1);
      add_pixel(45, 100, 1);
      add_pixel(330, 99, 99);

      for (int i = 0; i < RANDOM_PIXELS; i++) begin
         pick = $urandom_range(99);
         if (pick < 80) begin
            // legal saturation and brightness, hue 0 to 360 (360 wraps)
            add_pixel($urandom_range(360), $urandom_range(100), $urandom_range(100));
         end else if (pick < 95) begin
            // any bit pattern the fields allow
            add_pixel($urandom_range(511), $urandom_range(127), $urandom_range(127));
         end else begin
            // saturated extremes with a random hue
            add_pixel($urandom_range(360), ($urandom_range(1) != 0) ? 100 : 0,
                      ($urandom_range(1) != 0) ? 100 : 0);
         end
      end
      total = pixel_queue.size();

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // all requests taken, then every color back, then a quiet drain
      while (sent_count < total) @(posedge clock);
      while (pending_colors.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (pending_colors.size() > 0) begin
         $error("%0d responses never arrived", pending_colors.size());
         error_count++;
      end

      $display("covered %0d pixels (%0d with clamped or wrapped fields), %0d responses",
               sent_count, clamped_count, received_count);
      $display("all six hue sectors and their edges, random stalls on both sides");
      if (error_count == 0) begin
         $display("hsv_to_rgb565 regression: pass");
      end else begin
         $display("hsv_to_rgb565 regression: fail");
      end
      $finish;
   end

endmodule

FILE: hsv_to_rgb565.f
src/hsvr_pkg.sv
src/hsvr_prep.sv
src/hsvr_mix.sv
src/hsvr_quant.sv
src/hsv_to_rgb565.sv
tb/hsv_to_rgb565_tb.sv
